// ===== rtl/core/krs_pkg.sv =====
package krs_pkg;

    localparam int KEY_W   = 8;
    localparam int SW_W    = 8;
    localparam int DELAY_W = 16;
    localparam int ID_W    = 4;
    localparam int STEP_W  = 4;
    localparam int SEQ_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [SEQ_W-1:0] t_seq;

    localparam t_seq SEQ_IDLE  = 3'd0;
    localparam t_seq SEQ_ONE   = 3'd1;
    localparam t_seq SEQ_TWO   = 3'd2;
    localparam t_seq SEQ_THREE = 3'd3;
    localparam t_seq SEQ_FOUR  = 3'd4;
    localparam t_seq SEQ_FIVE  = 3'd5;
    localparam t_seq SEQ_SIX   = 3'd6;

    localparam logic [KEY_W-1:0] KEY_FIRST_SEQ = 8'd1;
    localparam logic [KEY_W-1:0] KEY_LAST_SEQ  = 8'd6;
    localparam logic [KEY_W-1:0] KEY_SEVEN     = 8'd7;
    localparam logic [KEY_W-1:0] KEY_EIGHT     = 8'd8;

    localparam logic [ID_W-1:0] RELAY_SIX   = 4'd6;
    localparam logic [ID_W-1:0] RELAY_SEVEN = 4'd7;
    localparam logic [ID_W-1:0] RELAY_EIGHT = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LEFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_RIGHT = 2'd2;

    localparam logic [DELAY_W-1:0] RST_STEP_DELAY   = 16'd1000;
    localparam logic [SW_W-1:0]    RST_ENABLE_LEFT  = 8'd1;
    localparam logic [SW_W-1:0]    RST_ENABLE_RIGHT = 8'd4;

    localparam logic [ID_W-1:0] SEQ25_ID [0:2] = '{4'd8, 4'd6, 4'd7};
    localparam logic [2:0]      SEQ25_LV = 3'b011;
    localparam logic [ID_W-1:0] SEQ3_ID [0:8] =
        '{4'd3, 4'd8, 4'd4, 4'd5, 4'd1, 4'd3, 4'd4, 4'd5, 4'd7};
    localparam logic [8:0]      SEQ3_LV = 9'b111100000;
    localparam logic [ID_W-1:0] SEQ6_ID [0:2] = '{4'd3, 4'd8, 4'd4};

    typedef struct packed {
        logic [ID_W-1:0] relay_id;
        logic            relay_level;
        logic            last_write;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_gen;

    typedef struct packed {
        logic [DELAY_W-1:0] step_delay;
        logic [SW_W-1:0]    enable_left;
        logic [SW_W-1:0]    enable_right;
    } t_cfg;

    typedef struct packed {
        logic            known;
        logic            hit;
        logic [ID_W-1:0] relay_id;
        logic            relay_level;
        logic            fin;
    } t_step_look;

    function automatic t_step_look step_lookup(t_seq seq, logic [STEP_W-1:0] idx);
        t_step_look r;
        r = '0;
        case (seq)
            SEQ_TWO, SEQ_FIVE: begin
                r.known = 1'b1;
                if (idx < 4'd3) begin
                    r.hit         = 1'b1;
                    r.relay_id    = SEQ25_ID[idx[1:0]];
                    r.relay_level = SEQ25_LV[idx[1:0]];
                    r.fin         = (idx == 4'd2);
                end
            end
            SEQ_THREE: begin
                r.known = 1'b1;
                if (idx < 4'd9) begin
                    r.hit         = 1'b1;
                    r.relay_id    = SEQ3_ID[idx];
                    r.relay_level = SEQ3_LV[idx];
                    r.fin         = (idx == 4'd8);
                end
            end
            SEQ_FOUR: begin
                r.known = 1'b1;
                if (idx == 4'd0) begin
                    r.hit         = 1'b1;
                    r.relay_id    = RELAY_SIX;
                    r.relay_level = 1'b0;
                    r.fin         = 1'b1;
                end
            end
            SEQ_SIX: begin
                r.known = 1'b1;
                if (idx < 4'd3) begin
                    r.hit         = 1'b1;
                    r.relay_id    = SEQ6_ID[idx[1:0]];
                    r.relay_level = 1'b0;
                    r.fin         = (idx == 4'd2);
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/krs_if.sv =====
interface krs_item_if;
    logic                      valid;
    logic                      ready;
    logic [krs_pkg::KEY_W-1:0] key_code;
    logic [krs_pkg::SW_W-1:0]  left_switch;
    logic [krs_pkg::SW_W-1:0]  right_switch;

    modport source (output valid, key_code, left_switch, right_switch, input ready);
    modport sink (input valid, key_code, left_switch, right_switch, output ready);
endinterface

interface krs_result_if;
    logic                     valid;
    logic                     ready;
    logic [krs_pkg::ID_W-1:0] relay_id;
    logic                     relay_level;
    logic                     last_write;

    modport source (output valid, relay_id, relay_level, last_write, input ready);
    modport sink (input valid, relay_id, relay_level, last_write, output ready);
endinterface

interface krs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [krs_pkg::CFG_IDX_W-1:0]  index;
    logic [krs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/krs_seq.sv =====
module krs_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [krs_pkg::KEY_W-1:0] i_key,
    input  logic [krs_pkg::SW_W-1:0]  i_left,
    input  logic [krs_pkg::SW_W-1:0]  i_right,
    input  krs_pkg::t_cfg             i_cfg,
    output krs_pkg::t_gen             o_gen
);

    krs_pkg::t_seq                    r_seq,  n_seq;
    logic [krs_pkg::STEP_W-1:0]       r_step, n_step;
    logic [krs_pkg::DELAY_W-1:0]      r_wait, n_wait;
    logic [krs_pkg::KEY_W-1:0]        r_prev, n_prev;
    logic                             r_h7, n_h7;
    logic                             r_h8, n_h8;
    logic                             r_t7, n_t7;
    logic                             r_t8, n_t8;

    logic                             mode;
    logic                             start;
    krs_pkg::t_seq                    seq;
    logic [krs_pkg::STEP_W-1:0]       step;
    logic [krs_pkg::DELAY_W-1:0]      wt;
    logic                             k7_up;
    logic                             k8_up;
    logic                             go;
    krs_pkg::t_step_look              look;
    logic                             tg_v;
    logic [krs_pkg::ID_W-1:0]         tg_id;
    logic                             tg_lv;
    logic                             st_v;
    logic [krs_pkg::ID_W-1:0]         st_id;
    logic                             st_lv;

    always_comb begin
        n_seq  = r_seq;
        n_step = r_step;
        n_wait = r_wait;
        n_prev = r_prev;
        n_h7   = r_h7;
        n_h8   = r_h8;
        n_t7   = r_t7;
        n_t8   = r_t8;
        tg_v   = 1'b0;
        tg_id  = '0;
        tg_lv  = 1'b0;
        st_v   = 1'b0;
        st_id  = '0;
        st_lv  = 1'b0;
        go     = 1'b0;

        mode  = (i_left == i_cfg.enable_left) && (i_right == i_cfg.enable_right);
        start = (i_key != r_prev)
             && (i_key inside {[krs_pkg::KEY_FIRST_SEQ:krs_pkg::KEY_LAST_SEQ]});
        seq   = start ? i_key[krs_pkg::SEQ_W-1:0] : r_seq;
        step  = start ? '0 : r_step;
        wt    = start ? '0 : r_wait;
        k7_up = (i_key == krs_pkg::KEY_SEVEN) && !(start ? 1'b0 : r_h7);
        k8_up = (i_key == krs_pkg::KEY_EIGHT) && !(start ? 1'b0 : r_h8);
        look  = krs_pkg::step_lookup(seq, step);

        if (!mode) begin
            n_seq  = krs_pkg::SEQ_IDLE;
            n_step = '0;
            n_wait = '0;
            n_prev = '0;
            n_h7   = 1'b0;
            n_h8   = 1'b0;
        end else begin
            n_seq  = seq;
            n_step = step;
            n_wait = wt;
            n_prev = i_key;
            n_h7   = (i_key == krs_pkg::KEY_SEVEN);
            n_h8   = (i_key == krs_pkg::KEY_EIGHT);

            if (seq == krs_pkg::SEQ_ONE) begin
                if (k7_up) begin
                    n_t8  = ~r_t8;
                    tg_v  = 1'b1;
                    tg_id = krs_pkg::RELAY_EIGHT;
                    tg_lv = ~r_t8;
                end
                if (step == '0) begin
                    st_v   = 1'b1;
                    st_id  = krs_pkg::RELAY_SIX;
                    st_lv  = 1'b0;
                    n_step = 4'd1;
                end
            end else begin
                if (seq == krs_pkg::SEQ_TWO) begin
                    if (k7_up) begin
                        n_t7  = ~r_t7;
                        tg_v  = 1'b1;
                        tg_id = krs_pkg::RELAY_SEVEN;
                        tg_lv = ~r_t7;
                    end
                    if (k8_up) begin
                        n_t8  = ~r_t8;
                        tg_v  = 1'b1;
                        tg_id = krs_pkg::RELAY_EIGHT;
                        tg_lv = ~r_t8;
                    end
                end
                if (seq != krs_pkg::SEQ_IDLE) begin
                    go = 1'b1;
                    if (step != '0) begin
                        if (wt < i_cfg.step_delay) begin
                            n_wait = wt + 16'd1;
                            go     = 1'b0;
                        end else begin
                            n_wait = '0;
                        end
                    end
                    if (go) begin
                        if (!look.known) begin
                            n_seq = krs_pkg::SEQ_IDLE;
                        end else if (look.hit) begin
                            st_v  = 1'b1;
                            st_id = look.relay_id;
                            st_lv = look.relay_level;
                            if (look.fin) begin
                                n_seq = krs_pkg::SEQ_IDLE;
                            end else begin
                                n_step = step + 4'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_gen.count = {1'b0, tg_v} + {1'b0, st_v};
        o_gen.res0.relay_id    = tg_v ? tg_id : st_id;
        o_gen.res0.relay_level = tg_v ? tg_lv : st_lv;
        o_gen.res0.last_write  = !(tg_v && st_v);
        o_gen.res1.relay_id    = st_id;
        o_gen.res1.relay_level = st_lv;
        o_gen.res1.last_write  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= krs_pkg::SEQ_IDLE;
            r_step <= '0;
            r_wait <= '0;
            r_prev <= '0;
            r_h7   <= 1'b0;
            r_h8   <= 1'b0;
            r_t7   <= 1'b0;
            r_t8   <= 1'b0;
        end else if (i_fire) begin
            r_seq  <= n_seq;
            r_step <= n_step;
            r_wait <= n_wait;
            r_prev <= n_prev;
            r_h7   <= n_h7;
            r_h8   <= n_h8;
            r_t7   <= n_t7;
            r_t8   <= n_t8;
        end
    end

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !mode |=> r_seq == krs_pkg::SEQ_IDLE && r_step == '0 && r_wait == '0)
        else $error("Sequence state not cleared outside the mode.");

    a_wait_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && mode && !start && r_seq != krs_pkg::SEQ_ONE
        && r_seq != krs_pkg::SEQ_IDLE && r_step != '0 && r_wait < i_cfg.step_delay
        |-> o_gen.count == {1'b0, tg_v})
        else $error("Sequence step taken during the wait.");

    a_toggle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !mode |=> r_t7 == $past(r_t7) && r_t8 == $past(r_t8))
        else $error("Toggle state changed outside the mode.");

endmodule

// ===== rtl/core/keyed_relay_sequencer.sv =====
// Keyed relay sequencer. Each input item is one remote tick carrying the key
// code and the two mode switch positions; each result item is one relay write
// with its relay number, level and a flag on the final write of that tick.
// A tick causes zero, one or two writes.
// All three channels use a valid and ready handshake. The configuration channel
// is always ready and writes step_delay, enable_left or enable_right
// by index; other indexes are ignored. Write it only while the block is idle.
// An accepted item is held in an input register until the result queue has
// room; the sequencer logic then loads its writes into a two-entry result
// queue, whose first entry is offered on the result channel.
// The block accepts one item per cycle while the receiver keeps up and each
// item gives at most one write. An item with two writes holds off the next
// item until its second write is being taken.
// Synchronous reset clears the sequence state, toggle bits and queues and loads
// the register defaults. When the receiver stalls, the queue holds its writes,
// the input register holds the next item and input ready falls.
module keyed_relay_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    krs_item_if.sink             i_item,
    krs_result_if.source         o_result,
    krs_cfg_if.sink              i_cfg
);

    logic                        r_in_v;
    logic [krs_pkg::KEY_W-1:0]   r_key;
    logic [krs_pkg::SW_W-1:0]    r_left;
    logic [krs_pkg::SW_W-1:0]    r_right;
    krs_pkg::t_cfg               r_cfg;
    logic [1:0]                  r_cnt;
    krs_pkg::t_result            r_q0;
    krs_pkg::t_result            r_q1;

    krs_pkg::t_gen               gen;
    logic                        pop;
    logic                        out_free;
    logic                        fire;

    assign pop      = o_result.valid && o_result.ready;
    assign out_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign fire     = r_in_v && out_free;

    assign i_item.ready = !r_in_v || fire;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid       = (r_cnt != 2'd0);
    assign o_result.relay_id    = r_q0.relay_id;
    assign o_result.relay_level = r_q0.relay_level;
    assign o_result.last_write  = r_q0.last_write;

    krs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_key   (r_key),
        .i_left  (r_left),
        .i_right (r_right),
        .i_cfg   (r_cfg),
        .o_gen   (gen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_key   <= i_item.key_code;
            r_left  <= i_item.left_switch;
            r_right <= i_item.right_switch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay   <= krs_pkg::RST_STEP_DELAY;
            r_cfg.enable_left  <= krs_pkg::RST_ENABLE_LEFT;
            r_cfg.enable_right <= krs_pkg::RST_ENABLE_RIGHT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                krs_pkg::CFG_STEP_DELAY: begin
                    r_cfg.step_delay <= i_cfg.data;
                end
                krs_pkg::CFG_ENABLE_LEFT: begin
                    r_cfg.enable_left <= i_cfg.data[krs_pkg::SW_W-1:0];
                end
                krs_pkg::CFG_ENABLE_RIGHT: begin
                    r_cfg.enable_right <= i_cfg.data[krs_pkg::SW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (fire) begin
            r_cnt <= gen.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_q0 <= gen.res0;
            r_q1 <= gen.res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    a_pair_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_cnt == 2'd2 |=> r_cnt == 2'd1 && o_result.valid)
        else $error("Second write of an item lost.");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !r_q0.last_write && r_q1.last_write)
        else $error("Last flag misplaced on a two-write item.");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd1 |-> r_q0.last_write)
        else $error("Single pending write without last flag.");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v && !fire |=> r_in_v && $stable(r_key) && $stable(r_left))
        else $error("Pending item lost while the queue was full.");

endmodule
